### hw/rtl/spr_pkg.sv
package spr_pkg;

    // Operation codes of an input word
    localparam logic [1:0] OP_RAW     = 2'd0;
    localparam logic [1:0] OP_BOUNDED = 2'd1;
    localparam logic [1:0] OP_RESEED  = 2'd2;

    // Engine codes
    localparam logic [1:0] ALG_XS  = 2'd0;
    localparam logic [1:0] ALG_PCG = 2'd1;
    localparam logic [1:0] ALG_LCG = 2'd2;

    // Configuration register indexes
    localparam int         CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALG  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED = 1'b1;

    localparam logic [63:0] PRNG_MUL    = 64'd6364136223846793005;
    localparam logic [63:0] LCG_ADD     = 64'd1442695040888963407;
    localparam logic [63:0] XS_SEED_MIX = 64'h6C3F2A1B9E7D5C4A;
    localparam logic [31:0] PRNG_MUL_LO = PRNG_MUL[31:0];
    localparam logic [31:0] PRNG_MUL_HI = PRNG_MUL[63:32];

    localparam int XS_WARMUP = 20;
    localparam int WARM_W    = $clog2(XS_WARMUP);

    // Status of a multi-cycle arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic [31:0] raw;
    } t_xs;

    // One xorshift128+ step
    function automatic t_xs xs_step(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] t;
        logic [63:0] nb;
        t_xs         r;
        t     = a ^ (a << 23);
        nb    = t ^ b ^ (t >> 17) ^ (b >> 26);
        r.a   = b;
        r.b   = nb;
        r.raw = nb[31:0] + b[31:0];
        return r;
    endfunction

endpackage

### hw/rtl/spr_mul.sv
module spr_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [63:0]        i_a,
    input  logic [63:0]        i_c,
    output spr_pkg::t_unit_sts o_sts,
    output logic [63:0]        o_prod
);
    import spr_pkg::*;

    // a * PRNG_MUL + c, low 64 bits, from three 32x32 partial products
    logic [63:0] r_a;
    logic [63:0] r_acc;
    logic [63:0] r_prod;
    logic [1:0]  r_step;
    logic        r_busy;
    logic        r_done;

    logic [31:0] mul_x;
    logic [31:0] mul_y;
    logic [63:0] mul_p;

    always_comb begin
        mul_x = (r_step == 2'd1) ? r_a[63:32] : r_a[31:0];
        mul_y = (r_step == 2'd2) ? PRNG_MUL_HI : PRNG_MUL_LO;
        mul_p = 64'(mul_x) * 64'(mul_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 2'd0;
        end else begin
            r_done <= !i_start && r_busy && (r_step == 2'd3);
            if (i_start) begin
                r_a    <= i_a;
                r_acc  <= i_c;
                r_step <= 2'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                // cross products only reach the upper word
                if (r_step == 2'd0) begin
                    r_prod <= mul_p;
                end else begin
                    r_prod <= {mul_p[31:0], 32'd0};
                end
                if (r_step != 2'd0) begin
                    r_acc <= r_acc + r_prod;
                end
                if (r_step == 2'd3) begin
                    r_busy <= 1'b0;
                end
                r_step <= r_step + 2'd1;
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_prod     = r_acc;

endmodule

### hw/rtl/spr_mod.sv
module spr_mod (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [31:0]        i_dividend,
    input  logic [30:0]        i_divisor,
    output spr_pkg::t_unit_sts o_sts,
    output logic [30:0]        o_rem
);
    import spr_pkg::*;

    // Restoring remainder, one dividend bit per cycle
    logic [31:0] r_num;
    logic [30:0] r_div;
    logic [30:0] r_rem;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [31:0] trial;
    logic [31:0] diff;
    logic [30:0] rem_nx;

    always_comb begin
        trial = {r_rem, r_num[31]};
        diff  = trial - {1'b0, r_div};
        if (trial >= {1'b0, r_div}) begin
            rem_nx = diff[30:0];
        end else begin
            rem_nx = trial[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == 5'd31);
            if (i_start) begin
                r_num  <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= 31'd0;
                r_cnt  <= 5'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= rem_nx;
                r_num <= {r_num[30:0], 1'b0};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_rem      = r_rem;

endmodule

### hw/rtl/selectable_prng_with_range.sv
// Random generator with three engines: xorshift128+, PCG32 and a 64-bit LCG.
// Configuration: write i_cfg_data to register i_cfg_index when i_cfg_we is
// high; index 0 selects the engine, index 1 holds the reseed seed. Write only
// while no request is in flight.
// Request channel (i_valid/o_ready): operation 0 asks for a raw value,
// 1 for a value below i_bound (zero when i_bound is 0), 2 reseeds the selected engine.
// Result channel (o_valid/i_ready): one word of o_value per request.
// One request at a time; o_ready is high only while the sequencer is idle,
// so the next request is taken at the earliest in the cycle after a word loads.
// A raw xorshift value or an immediate zero goes straight to the finish
// state; a PCG or LCG step waits for the shared 32x32 multiplier, which
// runs three partial products, and an xorshift reseed runs 20 warm-up steps.
// A bounded request also passes through the bit-serial remainder unit.
// The result sits in an output register; while the receiver stalls the
// finished word waits there and a new request is still taken, but its
// result cannot leave the sequencer until the register frees up.
// Reset: seed 1, engine 0, engine state zero with PCG increment 1.
module selectable_prng_with_range (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [1:0]                       i_operation,
    input  logic [30:0]                      i_bound,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [31:0]                      o_value,
    input  logic                             i_cfg_we,
    input  logic [spr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [63:0]                      i_cfg_data
);
    import spr_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_WARM = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    localparam logic [WARM_W-1:0] WARM_LAST = WARM_W'(XS_WARMUP - 1);

    t_state            r_state;
    logic [1:0]        r_alg;
    logic [63:0]       r_seed;
    logic [63:0]       r_xs_a;
    logic [63:0]       r_xs_b;
    logic [63:0]       r_pcg_word;
    logic [63:0]       r_pcg_inc;
    logic [63:0]       r_lcg_word;
    logic [1:0]        r_op;
    logic [30:0]       r_bound;
    logic [31:0]       r_raw;
    logic [31:0]       r_res;
    logic [WARM_W-1:0] r_warm;
    logic              r_out_valid;
    logic [31:0]       r_value;

    logic        accept;
    logic        load_out;
    logic [1:0]  op_cur;
    logic        is_gen;
    logic        is_seed;
    t_xs         xs_nx;
    logic [31:0] pcg_x;
    logic [63:0] pcg_rot;
    logic [31:0] pcg_out;
    logic [63:0] seed_inc;
    logic [31:0] raw_val;
    logic        mul_start;
    logic [63:0] mul_a;
    logic [63:0] mul_c;
    logic        mod_start;
    logic [30:0] mod_div;
    t_unit_sts   mul_sts;
    t_unit_sts   mod_sts;
    logic [63:0] mul_prod;
    logic [30:0] mod_rem;

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign load_out = (r_state == S_FIN) && (!r_out_valid || i_ready);
    assign op_cur   = (r_state == S_IDLE) ? i_operation : r_op;
    assign is_gen   = (i_operation == OP_RAW) ||
                      ((i_operation == OP_BOUNDED) && (i_bound != 31'd0));
    assign is_seed  = (i_operation == OP_RESEED);

    assign xs_nx    = xs_step(r_xs_a, r_xs_b);
    assign seed_inc = {r_seed[62:0], 1'b1};

    // PCG XSH-RR output taken from the state before the step
    always_comb begin
        pcg_x   = 32'(((r_pcg_word >> 18) ^ r_pcg_word) >> 27);
        pcg_rot = {pcg_x, pcg_x} >> r_pcg_word[63:59];
        pcg_out = pcg_rot[31:0];
    end

    always_comb begin
        mul_start = 1'b0;
        mul_a     = r_lcg_word;
        mul_c     = LCG_ADD;
        if (accept) begin
            unique case (r_alg)
                ALG_PCG: begin
                    mul_start = is_gen || is_seed;
                    if (is_seed) begin
                        mul_a = seed_inc + r_seed;
                        mul_c = seed_inc;
                    end else begin
                        mul_a = r_pcg_word;
                        mul_c = r_pcg_inc;
                    end
                end
                ALG_LCG: begin
                    mul_start = is_gen;
                end
                default: begin
                    mul_start = 1'b0;
                end
            endcase
        end
    end

    // Raw value becomes known either at acceptance (xorshift, PCG) or when the
    // multiplier finishes (LCG)
    always_comb begin
        if (r_state == S_IDLE) begin
            raw_val   = xs_nx.raw;
            mod_start = accept && is_gen && (r_alg == ALG_XS) &&
                        (i_operation == OP_BOUNDED);
        end else begin
            raw_val   = (r_alg == ALG_PCG) ? r_raw : mul_prod[63:32];
            mod_start = (r_state == S_MUL) && mul_sts.done && (op_cur == OP_BOUNDED);
        end
        mod_div = (r_state == S_IDLE) ? i_bound : r_bound;
    end

    spr_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_c     (mul_c),
        .o_sts   (mul_sts),
        .o_prod  (mul_prod)
    );

    spr_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (raw_val),
        .i_divisor  (mod_div),
        .o_sts      (mod_sts),
        .o_rem      (mod_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_alg       <= ALG_XS;
            r_seed      <= 64'd1;
            r_xs_a      <= 64'd0;
            r_xs_b      <= 64'd0;
            r_pcg_word  <= 64'd0;
            r_pcg_inc   <= 64'd1;
            r_lcg_word  <= 64'd0;
            r_warm      <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ALG:  r_alg  <= i_cfg_data[1:0];
                    CFG_SEED: r_seed <= i_cfg_data;
                    default:  r_seed <= r_seed;
                endcase
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op    <= i_operation;
                        r_bound <= i_bound;
                        unique case (r_alg)
                            ALG_XS: begin
                                if (is_gen) begin
                                    r_xs_a <= xs_nx.a;
                                    r_xs_b <= xs_nx.b;
                                    r_res  <= xs_nx.raw;
                                    if (i_operation == OP_BOUNDED) begin
                                        r_state <= S_DIV;
                                    end else begin
                                        r_state <= S_FIN;
                                    end
                                end else if (is_seed) begin
                                    r_xs_a  <= r_seed;
                                    r_xs_b  <= r_seed ^ XS_SEED_MIX;
                                    r_warm  <= '0;
                                    r_res   <= 32'd0;
                                    r_state <= S_WARM;
                                end else begin
                                    r_res   <= 32'd0;
                                    r_state <= S_FIN;
                                end
                            end
                            ALG_PCG: begin
                                r_res <= 32'd0;
                                if (is_gen) begin
                                    r_raw   <= pcg_out;
                                    r_state <= S_MUL;
                                end else if (is_seed) begin
                                    r_pcg_inc <= seed_inc;
                                    r_state   <= S_MUL;
                                end else begin
                                    r_state <= S_FIN;
                                end
                            end
                            ALG_LCG: begin
                                r_res <= 32'd0;
                                if (is_gen) begin
                                    r_state <= S_MUL;
                                end else begin
                                    if (is_seed) begin
                                        r_lcg_word <= r_seed;
                                    end
                                    r_state <= S_FIN;
                                end
                            end
                            default: begin
                                r_res   <= 32'd0;
                                r_state <= S_FIN;
                            end
                        endcase
                    end
                end
                S_WARM: begin
                    r_xs_a <= xs_nx.a;
                    r_xs_b <= xs_nx.b;
                    r_warm <= r_warm + WARM_W'(1);
                    if (r_warm == WARM_LAST) begin
                        r_state <= S_FIN;
                    end
                end
                S_MUL: begin
                    if (mul_sts.done) begin
                        if (r_alg == ALG_PCG) begin
                            r_pcg_word <= mul_prod;
                        end else begin
                            r_lcg_word <= mul_prod;
                        end
                        if (r_op == OP_BOUNDED) begin
                            r_state <= S_DIV;
                        end else begin
                            if (r_op == OP_RAW) begin
                                r_res <= raw_val;
                            end
                            r_state <= S_FIN;
                        end
                    end
                end
                S_DIV: begin
                    if (mod_sts.done) begin
                        r_res   <= {1'b0, mod_rem};
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // hold the word until the output register frees up
                    if (load_out) begin
                        r_value <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_value = r_value;

`ifndef SYNTHESIS
    a_mul_done_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_sts.done |-> (r_state == S_MUL))
        else $error("multiplier finished outside its wait state");

    a_mod_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_sts.done |-> (r_state == S_DIV))
        else $error("remainder unit finished outside its wait state");

    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_sts.busy && mod_sts.busy))
        else $error("multiplier and remainder unit busy together");

    a_pcg_inc_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcg_inc[0])
        else $error("PCG increment became even");

    a_reseed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FIN) && (r_op == OP_RESEED)) |-> (r_res == 32'd0))
        else $error("reseed produced a nonzero word");
`endif

endmodule
